// ===== design/mrfm_pkg.sv =====
// ----------------------------------------------------------------------------
// mrfm_pkg
// shared types, codes and the region attribute builder of the fault manager
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mrfm_pkg;

	localparam logic [2:0] REQ_MAP        = 3'd0;
	localparam logic [2:0] REQ_UNMAP      = 3'd1;
	localparam logic [2:0] REQ_FAULT      = 3'd2;
	localparam logic [2:0] REQ_ACTIVATE   = 3'd3;
	localparam logic [2:0] REQ_DEACTIVATE = 3'd4;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_REJECTED  = 3'd1;
	localparam logic [2:0] ST_NO_SPACE  = 3'd2;
	localparam logic [2:0] ST_INVALID   = 3'd3;
	localparam logic [2:0] ST_DENIED    = 3'd4;
	localparam logic [2:0] ST_NO_REGION = 3'd5;

	localparam logic [1:0] OP_NONE        = 2'd0;
	localparam logic [1:0] OP_PROGRAM     = 2'd1;
	localparam logic [1:0] OP_DISABLE     = 2'd2;
	localparam logic [1:0] OP_DISABLE_ALL = 2'd3;

	localparam int PERM_R = 0;
	localparam int PERM_W = 1;
	localparam int PERM_X = 2;
	localparam int PERM_U = 3;

	localparam logic [2:0] REG_HW_REGIONS = 3'd0;

	localparam logic [31:0] ATTR_FIXED = (32'd1 << 18) | (32'd1 << 17) | (32'd1 << 16) | 32'd1;

	typedef enum logic [6:0] {
		S_IDLE    = 7'b0000001,
		S_SCAN_RD = 7'b0000010,
		S_SCAN_CM = 7'b0000100,
		S_DECIDE  = 7'b0001000,
		S_REG_SEL = 7'b0010000,
		S_REG_CMP = 7'b0100000,
		S_LOAD    = 7'b1000000
	} state_t;

	function automatic logic [31:0] build_attr(input logic [3:0] p, input logic [4:0] szf);
		logic [31:0] ap;
		logic [31:0] xn;
		begin
			if (p[PERM_U]) ap = p[PERM_W] ? 32'd3 : 32'd6;
			else ap = p[PERM_W] ? 32'd1 : 32'd5;
			xn = p[PERM_X] ? 32'd0 : 32'd1;
			build_attr = (xn << 28) | (ap << 24) | ATTR_FIXED | ({27'd0, szf} << 1);
		end
	endfunction

endpackage

`default_nettype wire

// ===== design/mpu_region_fault_manager_top.sv =====
// ----------------------------------------------------------------------------
// mpu_region_fault_manager_top
// page mapping table and mpu page-region manager with pinned-page eviction
//
// channel   signals                                   handshake
// request   start, req_type .. fault_pc               start && !busy
// result    done, status .. status_clear              done, one cycle
// config    psel penable pwrite paddr pwdata prdata   apb, pready high
//
// a transaction walks the mapping table, reading and then comparing each
// entry; a fault then walks the page regions, selecting each and comparing
// the age of each one in use, and a resident remap reloads its region;
// activate/deactivate, rejects and faults without a space skip the walk
// mapping table records live in a synchronous memory with registered reads
// arst_n clears flags, residency, region owners, counter and the register
// results cannot be stalled; done pulses once per transaction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mpu_region_fault_manager_top
	import mrfm_pkg::*;
#(
	parameter int MAPPINGS  = 16,
	parameter int REGIONS   = 8,
	parameter int PAGE_BITS = 10
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  req_type,
	input  wire logic [31:0] address,
	input  wire logic [3:0]  perms,
	input  wire logic        pinned,
	input  wire logic [7:0]  fault_status,
	input  wire logic [31:0] fault_pc,
	output logic             done,
	output logic [2:0]       status,
	output logic [1:0]       mpu_op,
	output logic [2:0]       mpu_region,
	output logic [31:0]      mpu_base,
	output logic [31:0]      mpu_attr,
	output logic [31:0]      fault_address,
	output logic [7:0]       status_clear,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int IW = (MAPPINGS > 1) ? $clog2(MAPPINGS) : 1;
	localparam int RB = $clog2(REGIONS);
	localparam int PW = 32 - PAGE_BITS;
	localparam int RW = PW + 4 + RB + 32;
	localparam logic [IW-1:0] LAST_IDX = IW'(MAPPINGS - 1);
	localparam logic [4:0] SZF = 5'(PAGE_BITS - 1);

	state_t state_q;

	logic [RW-1:0] mem [MAPPINGS];
	logic [RW-1:0] rd_data_q;
	logic [IW-1:0] rd_addr;
	logic          mem_we;
	logic [IW-1:0] mem_wa;
	logic [RW-1:0] mem_wd;

	logic [MAPPINGS-1:0] present_q, pin_q, resident_q;
	logic [IW-1:0]       owner_q [REGIONS];
	logic [REGIONS-1:0]  used_q;
	logic [31:0]         counter_q;
	logic                active_q;
	logic [3:0]          hw_q;

	logic [2:0]    req_q;
	logic [PW-1:0] page_q;
	logic [3:0]    perms_q;
	logic          pinreq_q;
	logic [7:0]    fs_q;
	logic [IW-1:0] scan_q;
	logic          hit_q, free_vld_q;
	logic [IW-1:0] hit_idx_q, free_idx_q;
	logic [RB-1:0] hit_reg_q;
	logic [31:0]   hit_stamp_q;
	logic [3:0]    hit_perms_q;
	logic [4:0]    c_q;
	logic          ev_vld_q;
	logic [RB-1:0] ev_reg_q, r_q;
	logic [31:0]   ev_stamp_q;

	logic          done_q;
	logic [2:0]    status_q;
	logic [1:0]    op_q;
	logic [2:0]    region_q;
	logic [31:0]   base_q, attr_q, fa_out_q;
	logic [7:0]    clr_q;

	logic [4:0]    limit;
	logic [31:0]   fa_in;
	logic [PW-1:0] rd_page;
	logic [3:0]    rd_perms;
	logic [RB-1:0] rd_reg;
	logic [31:0]   rd_stamp;
	logic [IW-1:0] cur_owner;
	logic [31:0]   r_wide;
	logic [31:0]   stamp_next;

	assign limit = ({1'b0, hw_q} < 5'(REGIONS)) ? {1'b0, hw_q} : 5'(REGIONS);
	assign fa_in = fault_status[0] ? fault_pc : (fault_status[7] ? address : 32'd0);
	assign {rd_page, rd_perms, rd_reg, rd_stamp} = rd_data_q;
	assign cur_owner = owner_q[c_q[RB-1:0]];
	assign r_wide = 32'(r_q);
	assign stamp_next = counter_q + 32'd1;

	always_comb begin
		rd_addr = scan_q;
		if (state_q == S_REG_SEL) begin
			rd_addr = cur_owner;
		end
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = hit_idx_q;
		mem_wd = {page_q, perms_q, hit_reg_q, hit_stamp_q};
		if (state_q == S_DECIDE && req_q == REQ_MAP) begin
			if (hit_q) begin
				mem_we = 1'b1;
			end else if (free_vld_q) begin
				mem_we = 1'b1;
				mem_wa = free_idx_q;
				mem_wd = {page_q, perms_q, {RB{1'b0}}, 32'd0};
			end
		end else if (state_q == S_LOAD) begin
			mem_we = 1'b1;
			mem_wd = {page_q, (req_q == REQ_MAP) ? perms_q : hit_perms_q, r_q, stamp_next};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= 4'd8;
		end else if (psel && penable && pwrite && paddr == REG_HW_REGIONS) begin
			hw_q <= pwdata[3:0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr == REG_HW_REGIONS) ? {28'd0, hw_q} : 32'd0;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q    <= req_type;
			perms_q  <= perms;
			pinreq_q <= pinned;
			fs_q     <= fault_status;
			page_q   <= (req_type == REQ_FAULT) ? fa_in[31:PAGE_BITS] : address[31:PAGE_BITS];
		end
		if (state_q == S_SCAN_CM && !hit_q && present_q[scan_q] && rd_page == page_q) begin
			hit_idx_q   <= scan_q;
			hit_reg_q   <= rd_reg;
			hit_stamp_q <= rd_stamp;
			hit_perms_q <= rd_perms;
		end
		if (state_q == S_SCAN_CM && !free_vld_q && !present_q[scan_q]) begin
			free_idx_q <= scan_q;
		end
		if (state_q == S_REG_CMP && !pin_q[cur_owner] && (!ev_vld_q || rd_stamp < ev_stamp_q)) begin
			ev_reg_q   <= c_q[RB-1:0];
			ev_stamp_q <= rd_stamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			present_q  <= '0;
			pin_q      <= '0;
			resident_q <= '0;
			used_q     <= '0;
			for (int k = 0; k < REGIONS; k++) owner_q[k] <= '0;
			counter_q  <= '0;
			active_q   <= 1'b0;
			scan_q     <= '0;
			hit_q      <= 1'b0;
			free_vld_q <= 1'b0;
			ev_vld_q   <= 1'b0;
			c_q        <= '0;
			r_q        <= '0;
			done_q     <= 1'b0;
			status_q   <= ST_OK;
			op_q       <= OP_NONE;
			region_q   <= '0;
			base_q     <= '0;
			attr_q     <= '0;
			fa_out_q   <= '0;
			clr_q      <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						status_q   <= ST_OK;
						op_q       <= OP_NONE;
						region_q   <= '0;
						base_q     <= '0;
						attr_q     <= '0;
						fa_out_q   <= (req_type == REQ_FAULT) ? fa_in : 32'd0;
						clr_q      <= '0;
						scan_q     <= '0;
						hit_q      <= 1'b0;
						free_vld_q <= 1'b0;
						ev_vld_q   <= 1'b0;
						priority if (req_type == REQ_ACTIVATE || req_type == REQ_DEACTIVATE) begin
							resident_q <= '0;
							used_q     <= '0;
							for (int k = 0; k < REGIONS; k++) owner_q[k] <= '0;
							active_q   <= (req_type == REQ_ACTIVATE);
							op_q       <= OP_DISABLE_ALL;
							done_q     <= 1'b1;
						end else if (req_type == REQ_MAP && (!perms[PERM_R] ||
							(perms[PERM_W] && perms[PERM_X]))) begin
							status_q <= ST_REJECTED;
							done_q   <= 1'b1;
						end else if (req_type == REQ_FAULT && !active_q) begin
							status_q <= ST_NO_SPACE;
							done_q   <= 1'b1;
						end else if (req_type == REQ_MAP || req_type == REQ_UNMAP ||
							req_type == REQ_FAULT) begin
							state_q <= S_SCAN_RD;
						end else begin
							status_q <= ST_REJECTED;
							done_q   <= 1'b1;
						end
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN_CM;
				end
				S_SCAN_CM: begin
					if (present_q[scan_q] && rd_page == page_q) hit_q <= 1'b1;
					if (!present_q[scan_q]) free_vld_q <= 1'b1;
					if (scan_q == LAST_IDX) begin
						state_q <= S_DECIDE;
					end else begin
						scan_q  <= scan_q + 1'b1;
						state_q <= S_SCAN_RD;
					end
				end
				S_DECIDE: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
					unique case (req_q)
						REQ_MAP: begin
							if (hit_q) begin
								pin_q[hit_idx_q] <= pinreq_q;
								if (resident_q[hit_idx_q] && active_q) begin
									r_q     <= hit_reg_q;
									state_q <= S_LOAD;
									done_q  <= 1'b0;
								end
							end else if (free_vld_q) begin
								present_q[free_idx_q]  <= 1'b1;
								pin_q[free_idx_q]      <= pinreq_q;
								resident_q[free_idx_q] <= 1'b0;
							end else begin
								status_q <= ST_REJECTED;
							end
						end
						REQ_UNMAP: begin
							if (!hit_q) begin
								status_q <= ST_REJECTED;
							end else begin
								if (resident_q[hit_idx_q] && active_q) begin
									op_q     <= OP_DISABLE;
									region_q <= 3'(32'(hit_reg_q));
									used_q[hit_reg_q]  <= 1'b0;
									owner_q[hit_reg_q] <= '0;
								end
								present_q[hit_idx_q]  <= 1'b0;
								pin_q[hit_idx_q]      <= 1'b0;
								resident_q[hit_idx_q] <= 1'b0;
							end
						end
						default: begin
							priority if (!hit_q) begin
								status_q <= ST_INVALID;
							end else if (resident_q[hit_idx_q]) begin
								status_q <= ST_DENIED;
							end else if (fs_q[0] && !hit_perms_q[PERM_X]) begin
								status_q <= ST_DENIED;
							end else begin
								c_q     <= 5'd1;
								state_q <= S_REG_SEL;
								done_q  <= 1'b0;
							end
						end
					endcase
				end
				S_REG_SEL: begin
					priority if (c_q >= limit) begin
						if (ev_vld_q) begin
							r_q     <= ev_reg_q;
							state_q <= S_LOAD;
						end else begin
							status_q <= ST_NO_REGION;
							state_q  <= S_IDLE;
							done_q   <= 1'b1;
						end
					end else if (!used_q[c_q[RB-1:0]]) begin
						r_q     <= c_q[RB-1:0];
						state_q <= S_LOAD;
					end else begin
						state_q <= S_REG_CMP;
					end
				end
				S_REG_CMP: begin
					if (!pin_q[cur_owner] && (!ev_vld_q || rd_stamp < ev_stamp_q)) begin
						ev_vld_q <= 1'b1;
					end
					c_q     <= c_q + 5'd1;
					state_q <= S_REG_SEL;
				end
				S_LOAD: begin
					if (used_q[r_q] && owner_q[r_q] != hit_idx_q) begin
						resident_q[owner_q[r_q]] <= 1'b0;
					end
					resident_q[hit_idx_q] <= 1'b1;
					owner_q[r_q] <= hit_idx_q;
					used_q[r_q]  <= 1'b1;
					counter_q    <= stamp_next;
					op_q         <= OP_PROGRAM;
					region_q     <= r_wide[2:0];
					base_q       <= {page_q, {PAGE_BITS{1'b0}}};
					attr_q       <= build_attr((req_q == REQ_MAP) ? perms_q : hit_perms_q, SZF);
					clr_q        <= (req_q == REQ_FAULT) ? fs_q : 8'd0;
					state_q      <= S_IDLE;
					done_q       <= 1'b1;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign mpu_op        = op_q;
	assign mpu_region    = region_q;
	assign mpu_base      = base_q;
	assign mpu_attr      = attr_q;
	assign fault_address = fa_out_q;
	assign status_clear  = clr_q;

`ifndef NO_ASSERTIONS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req_type <= REQ_FAULT && !(req_type == REQ_FAULT && !active_q) &&
		!(req_type == REQ_MAP && (!perms[PERM_R] || (perms[PERM_W] && perms[PERM_X]))))
		|=> busy)
		else $error("accepted table transaction did not go busy");
	a_fail_no_op: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_OK) |-> (mpu_op == OP_NONE))
		else $error("failed transaction issued an mpu operation");
	a_prog_attr: assert property (@(posedge clk) disable iff (!arst_n)
		(done && mpu_op == OP_PROGRAM) |-> (mpu_attr[0] && status == ST_OK))
		else $error("programmed region without enable");
	a_load_region: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LOAD) |-> (r_q != '0))
		else $error("load targets the flash region");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the mpu region fault manager: a queue-fed driver
// issues map, unmap, fault and activate/deactivate transactions in random
// bursts, a monitor compares every result with a cycle-free predictor, and
// the region count register is rewritten between phases while idle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
	import mrfm_pkg::*;

	typedef struct {
		logic [2:0]  req_type;
		logic [31:0] address;
		logic [3:0]  perms;
		logic        pinned;
		logic [7:0]  fault_status;
		logic [31:0] fault_pc;
	} request_t;

	typedef struct {
		logic [2:0]  status;
		logic [1:0]  mpu_op;
		logic [2:0]  mpu_region;
		logic [31:0] mpu_base;
		logic [31:0] mpu_attr;
		logic [31:0] fault_address;
		logic [7:0]  status_clear;
	} outcome_t;

	logic clk = 0, arst_n = 0;
	logic start = 0;
	logic [2:0] req_type = '0;
	logic [31:0] address = '0, fault_pc = '0;
	logic [3:0] perms = '0;
	logic pinned = 0;
	logic [7:0] fault_status = '0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	wire busy, done, pready;
	wire [2:0] status, mpu_region;
	wire [1:0] mpu_op;
	wire [31:0] mpu_base, mpu_attr, fault_address, prdata;
	wire [7:0] status_clear;

	mpu_region_fault_manager_top i_dut (.*);

	always #10 clk = ~clk;

	// predictor state
	logic [3:0]  hw_regions;
	logic [21:0] slot_page [16];
	logic [3:0]  slot_perms [16];
	bit          slot_present [16];
	bit          slot_pinned [16];
	bit          slot_resident [16];
	int          slot_region [16];
	logic [31:0] slot_stamp [16];
	int          region_slot [8];
	bit          region_taken [8];
	logic [31:0] load_count;
	bit          space_on;

	request_t pending_q[$];
	outcome_t outcome_q[$];
	request_t cur;
	int gap_left = 0, burst_left = 0;
	int mismatches = 0, results_seen = 0, faults_loaded = 0, evictions = 0;

	function automatic int find_slot(logic [31:0] a);
		for (int k = 0; k < 16; k++)
			if (slot_present[k] && slot_page[k] == a[31:10]) return k;
		return -1;
	endfunction

	function automatic void drop_residency();
		for (int k = 0; k < 16; k++) slot_resident[k] = 0;
		for (int k = 0; k < 8; k++) begin
			region_taken[k] = 0;
			region_slot[k] = 0;
		end
	endfunction

	function automatic logic [31:0] attr_word(logic [3:0] p);
		logic [31:0] ap;
		ap = p[3] ? (p[1] ? 32'd3 : 32'd6) : (p[1] ? 32'd1 : 32'd5);
		return ({31'd0, ~p[2]} << 28) | (ap << 24) | (32'd7 << 16) | (32'd9 << 1) | 32'd1;
	endfunction

	function automatic int place_page(int idx);
		int lim, r, o;
		bit found;
		logic [31:0] oldest;
		lim = hw_regions < 8 ? hw_regions : 8;
		r = -1;
		found = 0;
		oldest = 0;
		if (slot_resident[idx]) r = slot_region[idx];
		else
			for (int c = 1; c < lim; c++)
				if (!region_taken[c] && r < 0) r = c;
		if (r < 0)
			for (int c = 1; c < lim; c++) begin
				if (!region_taken[c]) continue;
				o = region_slot[c];
				if (slot_pinned[o]) continue;
				if (!found || slot_stamp[o] < oldest) begin
					found = 1;
					oldest = slot_stamp[o];
					r = c;
				end
			end
		if (r < 0) return -1;
		if (region_taken[r] && region_slot[r] != idx) begin
			slot_resident[region_slot[r]] = 0;
			evictions++;
		end
		slot_region[idx] = r;
		slot_resident[idx] = 1;
		load_count = load_count + 1;
		slot_stamp[idx] = load_count;
		region_slot[r] = idx;
		region_taken[r] = 1;
		return r;
	endfunction

	function automatic void fill_program(ref outcome_t o, input int idx, input int r);
		o.mpu_op = OP_PROGRAM;
		o.mpu_region = r[2:0];
		o.mpu_base = {slot_page[idx], 10'd0};
		o.mpu_attr = attr_word(slot_perms[idx]);
	endfunction

	function automatic outcome_t predict(request_t q);
		outcome_t o;
		int i, r;
		logic [31:0] fa;
		o = '{default: '0};
		case (q.req_type)
			REQ_MAP: begin
				if (!q.perms[PERM_R] || (q.perms[PERM_W] && q.perms[PERM_X])) begin
					o.status = ST_REJECTED;
				end else begin
					i = find_slot(q.address);
					if (i >= 0) begin
						slot_perms[i] = q.perms;
						slot_pinned[i] = q.pinned;
						if (slot_resident[i] && space_on) begin
							r = place_page(i);
							if (r >= 0) fill_program(o, i, r);
						end
					end else begin
						for (int k = 0; k < 16; k++)
							if (!slot_present[k] && i < 0) i = k;
						if (i < 0) o.status = ST_REJECTED;
						else begin
							slot_page[i] = q.address[31:10];
							slot_perms[i] = q.perms;
							slot_stamp[i] = 0;
							slot_resident[i] = 0;
							slot_region[i] = 0;
							slot_present[i] = 1;
							slot_pinned[i] = q.pinned;
						end
					end
				end
			end
			REQ_UNMAP: begin
				i = find_slot(q.address);
				if (i < 0) o.status = ST_REJECTED;
				else begin
					if (slot_resident[i] && space_on) begin
						r = slot_region[i];
						o.mpu_op = OP_DISABLE;
						o.mpu_region = r[2:0];
						region_taken[r] = 0;
						region_slot[r] = 0;
					end
					slot_present[i] = 0;
					slot_pinned[i] = 0;
					slot_perms[i] = 0;
					slot_page[i] = 0;
					slot_resident[i] = 0;
					slot_region[i] = 0;
					slot_stamp[i] = 0;
				end
			end
			REQ_FAULT: begin
				fa = q.fault_status[0] ? q.fault_pc : (q.fault_status[7] ? q.address : 32'd0);
				o.fault_address = fa;
				if (!space_on) o.status = ST_NO_SPACE;
				else begin
					i = find_slot(fa);
					if (i < 0) o.status = ST_INVALID;
					else if (slot_resident[i]) o.status = ST_DENIED;
					else if (q.fault_status[0] && !slot_perms[i][PERM_X]) o.status = ST_DENIED;
					else begin
						r = place_page(i);
						if (r < 0) o.status = ST_NO_REGION;
						else begin
							fill_program(o, i, r);
							o.status_clear = q.fault_status;
							faults_loaded++;
						end
					end
				end
			end
			REQ_ACTIVATE, REQ_DEACTIVATE: begin
				drop_residency();
				space_on = (q.req_type == REQ_ACTIVATE);
				o.mpu_op = OP_DISABLE_ALL;
			end
			default: o.status = ST_REJECTED;
		endcase
		return o;
	endfunction

	function automatic logic [31:0] page_addr();
		logic [21:0] pg;
		int k;
		k = $urandom_range(0, 19);
		pg = (k < 16) ? 22'(k) : 22'h3FFFEC + 22'(k);
		if ($urandom_range(0, 19) == 0) return $urandom;
		return {pg, 10'($urandom)};
	endfunction

	function automatic request_t random_request();
		request_t q;
		int sel;
		q.address = $urandom;
		q.fault_pc = $urandom;
		q.fault_status = 8'($urandom);
		q.pinned = ($urandom_range(0, 4) == 0);
		q.perms = 4'($urandom);
		if ($urandom_range(0, 6) != 0) begin
			q.perms[PERM_R] = 1;
			if (q.perms[PERM_W]) q.perms[PERM_X] = 0;
		end
		sel = $urandom_range(0, 99);
		if (sel < 36) begin
			q.req_type = REQ_MAP;
			q.address = page_addr();
		end else if (sel < 48) begin
			q.req_type = REQ_UNMAP;
			q.address = page_addr();
		end else if (sel < 88) begin
			q.req_type = REQ_FAULT;
			case ($urandom_range(0, 4))
				0, 1: begin
					q.fault_status[0] = 1;
					q.fault_pc = page_addr();
				end
				2, 3: begin
					q.fault_status[0] = 0;
					q.fault_status[7] = 1;
					q.address = page_addr();
				end
				default: ;
			endcase
		end else if (sel < 94) q.req_type = REQ_ACTIVATE;
		else if (sel < 97) q.req_type = REQ_DEACTIVATE;
		else q.req_type = 3'($urandom_range(5, 7));
		return q;
	endfunction

	function automatic request_t make_req(logic [2:0] rt, logic [31:0] a, logic [3:0] p,
			logic pn, logic [7:0] fs, logic [31:0] pc);
		request_t q;
		q.req_type = rt;
		q.address = a;
		q.perms = p;
		q.pinned = pn;
		q.fault_status = fs;
		q.fault_pc = pc;
		return q;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) outcome_q.push_back(predict(cur));
			if (start && busy) begin
			end else if (gap_left > 0) begin
				gap_left--;
				start <= 0;
			end else if (pending_q.size() > 0) begin
				cur = pending_q.pop_front();
				req_type <= cur.req_type;
				address <= cur.address;
				perms <= cur.perms;
				pinned <= cur.pinned;
				fault_status <= cur.fault_status;
				fault_pc <= cur.fault_pc;
				start <= 1;
				if (burst_left == 0) begin
					gap_left = $urandom_range(1, 40);
					burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 10);
				end else burst_left--;
			end else start <= 0;
		end
	end

	// monitor
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			results_seen++;
			if (outcome_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result, status %0d", status);
			end else begin
				e = outcome_q.pop_front();
				if (e.status !== status || e.mpu_op !== mpu_op || e.mpu_region !== mpu_region ||
						e.mpu_base !== mpu_base || e.mpu_attr !== mpu_attr ||
						e.fault_address !== fault_address || e.status_clear !== status_clear) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: exp st %0d op %0d rg %0d base %h attr %h fa %h clr %h",
							e.status, e.mpu_op, e.mpu_region, e.mpu_base, e.mpu_attr,
							e.fault_address, e.status_clear);
						$display("          got st %0d op %0d rg %0d base %h attr %h fa %h clr %h",
							status, mpu_op, mpu_region, mpu_base, mpu_attr,
							fault_address, status_clear);
					end
				end
			end
		end
	end

	task automatic drain();
		do @(posedge clk); while (pending_q.size() > 0 || start || outcome_q.size() > 0);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_regions(logic [3:0] v);
		@(posedge clk);
		psel <= 1;
		pwrite <= 1;
		paddr <= REG_HW_REGIONS;
		pwdata <= {28'($urandom), v};
		penable <= 0;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		hw_regions = v;
	endtask

	initial begin
		logic [3:0] settings [7];
		settings = '{4'd2, 4'd8, 4'd0, 4'd1, 4'd15, 4'd3, 4'd5};
		hw_regions = 8;
		load_count = 0;
		space_on = 0;
		for (int k = 0; k < 16; k++) begin
			slot_page[k] = 0;
			slot_perms[k] = 0;
			slot_present[k] = 0;
			slot_pinned[k] = 0;
			slot_stamp[k] = 0;
			slot_region[k] = 0;
		end
		drop_residency();
		repeat (6) @(posedge clk);
		arst_n <= 1;

		// directed
		pending_q.push_back(make_req(REQ_FAULT, 32'h400, 0, 0, 8'h80, 0));
		pending_q.push_back(make_req(REQ_MAP, 32'h0, 4'h1, 0, 0, 0));
		pending_q.push_back(make_req(REQ_MAP, 32'hFFFFFFFF, 4'hB, 1, 8'hFF, 32'hFFFFFFFF));
		pending_q.push_back(make_req(REQ_MAP, 32'h800, 4'h7, 0, 0, 0));
		pending_q.push_back(make_req(REQ_MAP, 32'h800, 4'h6, 0, 0, 0));
		pending_q.push_back(make_req(REQ_MAP, 32'hC00, 4'hD, 0, 0, 0));
		pending_q.push_back(make_req(REQ_ACTIVATE, 0, 0, 0, 0, 0));
		pending_q.push_back(make_req(REQ_FAULT, 32'h123, 0, 0, 8'h00, 32'h55));
		pending_q.push_back(make_req(REQ_FAULT, 32'h123, 0, 0, 8'h00, 32'h55));
		pending_q.push_back(make_req(REQ_FAULT, 32'hFFFFFC00, 0, 0, 8'h80, 0));
		pending_q.push_back(make_req(REQ_FAULT, 32'h0, 0, 0, 8'h81, 32'hFFFFFFF0));
		pending_q.push_back(make_req(REQ_FAULT, 32'h0, 0, 0, 8'h01, 32'hC04));
		pending_q.push_back(make_req(REQ_FAULT, 32'h5000, 0, 0, 8'h80, 0));
		pending_q.push_back(make_req(REQ_MAP, 32'hC00, 4'h5, 1, 0, 0));
		pending_q.push_back(make_req(REQ_MAP, 32'hFFFFFFFF, 4'h3, 0, 0, 0));
		pending_q.push_back(make_req(REQ_UNMAP, 32'hFFFFFC00, 0, 0, 0, 0));
		pending_q.push_back(make_req(REQ_UNMAP, 32'h9000, 0, 0, 0, 0));
		pending_q.push_back(make_req(3'd5, 32'hFFFFFFFF, 4'hF, 1, 8'hFF, 32'hFFFFFFFF));
		pending_q.push_back(make_req(3'd7, 0, 0, 0, 0, 0));
		pending_q.push_back(make_req(REQ_DEACTIVATE, 0, 0, 0, 0, 0));
		pending_q.push_back(make_req(REQ_FAULT, 32'h0, 0, 0, 8'h01, 32'hC00));
		pending_q.push_back(make_req(REQ_UNMAP, 32'h0, 0, 0, 0, 0));
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			write_regions(settings[ph]);
			if (ph != 3) pending_q.push_back(make_req(REQ_ACTIVATE, 0, 0, 0, 0, 0));
			for (int n = 0; n < 240; n++) pending_q.push_back(random_request());
			drain();
		end

		$display("%0d results checked, %0d faults loaded a region, %0d evictions",
			results_seen, faults_loaded, evictions);
		$display("region counts 8, 2, 8, 0, 1, 15, 3 and 5 exercised");
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin
		#40ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
